/* hw/rtl/ntc_pkg.sv */
// shared types and constants of the numeric token classifier
package ntc_pkg;

    typedef enum logic [2:0] {
        TT_BLANK   = 3'd0,
        TT_STRING  = 3'd1,
        TT_INTEGER = 3'd2,
        TT_REAL    = 3'd3,
        TT_OPEN    = 3'd4,
        TT_CLOSE   = 3'd5,
        TT_WORD    = 3'd6
    } token_type_t;

    typedef enum logic [1:0] {
        BRACE_NONE  = 2'd0,
        BRACE_OPEN  = 2'd1,
        BRACE_CLOSE = 2'd2
    } brace_t;

    localparam logic [1:0] CNT_SAT = 2'd2;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_POINT  = 8'h2e;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_UC_E   = 8'h45;

    typedef struct packed {
        logic [1:0] char_count;
        logic       first_zero;
        logic       hex_prefix;
        logic       hex_digits_ok;
        logic       sign_seen;
        logic       point_seen;
        logic       exponent_seen;
        logic       int_possible;
        logic       float_possible;
        logic       digits_seen;
        brace_t     first_brace;
    } tok_state_t;

    localparam tok_state_t TOK_RESET = '{
        char_count:     2'd0,
        first_zero:     1'b0,
        hex_prefix:     1'b0,
        hex_digits_ok:  1'b1,
        sign_seen:      1'b0,
        point_seen:     1'b0,
        exponent_seen:  1'b0,
        int_possible:   1'b1,
        float_possible: 1'b1,
        digits_seen:    1'b0,
        first_brace:    BRACE_NONE
    };

endpackage

/* hw/rtl/ntc_char_update.sv */
// per-character update of the token flags
module ntc_char_update (
    input  ntc_pkg::tok_state_t cur,
    input  logic [7:0]          ch,
    input  logic                no_char,
    output ntc_pkg::tok_state_t nxt
);

    logic is_dec;
    logic is_hex;
    logic is_sign;
    logic is_point;
    logic is_exp;

    assign is_dec   = (ch >= ntc_pkg::CH_ZERO) && (ch <= ntc_pkg::CH_NINE);
    assign is_hex   = is_dec
                   || ((ch >= ntc_pkg::CH_LC_A) && (ch <= ntc_pkg::CH_LC_F))
                   || ((ch >= ntc_pkg::CH_UC_A) && (ch <= ntc_pkg::CH_UC_F));
    assign is_sign  = (ch == ntc_pkg::CH_PLUS) || (ch == ntc_pkg::CH_MINUS);
    assign is_point = (ch == ntc_pkg::CH_POINT);
    assign is_exp   = (ch == ntc_pkg::CH_LC_E) || (ch == ntc_pkg::CH_UC_E);

    always_comb begin
        nxt = cur;
        if (!no_char) begin
            case (cur.char_count)
                2'd0: begin
                    nxt.first_zero = (ch == ntc_pkg::CH_ZERO);
                    if (ch == ntc_pkg::CH_LBRACE) begin
                        nxt.first_brace = ntc_pkg::BRACE_OPEN;
                    end else if (ch == ntc_pkg::CH_RBRACE) begin
                        nxt.first_brace = ntc_pkg::BRACE_CLOSE;
                    end else begin
                        nxt.first_brace = ntc_pkg::BRACE_NONE;
                    end
                end
                2'd1: begin
                    nxt.hex_prefix = cur.first_zero && (ch == ntc_pkg::CH_X);
                end
                default: begin
                    if (!is_hex) begin
                        nxt.hex_digits_ok = 1'b0;
                    end
                end
            endcase
            if (cur.char_count < ntc_pkg::CNT_SAT) begin
                nxt.char_count = cur.char_count + 2'd1;
            end

            // grammar flags freeze after the first failure
            if (cur.float_possible) begin
                if (is_sign) begin
                    if (cur.sign_seen) begin
                        nxt.int_possible   = 1'b0;
                        nxt.float_possible = 1'b0;
                    end else begin
                        nxt.sign_seen = 1'b1;
                    end
                end else if (is_dec) begin
                    nxt.digits_seen = 1'b1;
                end else if (is_point) begin
                    if (cur.point_seen) begin
                        nxt.int_possible   = 1'b0;
                        nxt.float_possible = 1'b0;
                    end else begin
                        nxt.point_seen   = 1'b1;
                        nxt.int_possible = 1'b0;
                    end
                end else if (is_exp) begin
                    if (cur.exponent_seen || !cur.digits_seen) begin
                        nxt.int_possible   = 1'b0;
                        nxt.float_possible = 1'b0;
                    end else begin
                        // exponent starts a new part
                        nxt.exponent_seen = 1'b1;
                        nxt.int_possible  = 1'b0;
                        nxt.point_seen    = 1'b0;
                        nxt.sign_seen     = 1'b0;
                        nxt.digits_seen   = 1'b0;
                    end
                end else begin
                    nxt.int_possible   = 1'b0;
                    nxt.float_possible = 1'b0;
                end
            end
        end
    end

endmodule

/* hw/rtl/ntc_classify.sv */
// final token classification from the flags
module ntc_classify (
    input  ntc_pkg::tok_state_t  st,
    input  logic                 quoted,
    output ntc_pkg::token_type_t token_type
);

    always_comb begin
        if (st.char_count == 2'd0) begin
            token_type = ntc_pkg::TT_BLANK;
        end else if (quoted) begin
            token_type = ntc_pkg::TT_STRING;
        end else if ((st.char_count >= ntc_pkg::CNT_SAT) && st.hex_prefix
                     && st.hex_digits_ok) begin
            token_type = ntc_pkg::TT_INTEGER;
        end else if (st.int_possible && st.digits_seen) begin
            token_type = ntc_pkg::TT_INTEGER;
        end else if (st.float_possible && st.digits_seen) begin
            token_type = ntc_pkg::TT_REAL;
        end else if (st.first_brace == ntc_pkg::BRACE_OPEN) begin
            token_type = ntc_pkg::TT_OPEN;
        end else if (st.first_brace == ntc_pkg::BRACE_CLOSE) begin
            token_type = ntc_pkg::TT_CLOSE;
        end else begin
            token_type = ntc_pkg::TT_WORD;
        end
    end

endmodule

/* hw/rtl/numeric_token_classifier_unit.sv */
// top level of the numeric token classifier
//
// Usage: the characters of a token arrive on the s_ channel, one byte per
// item, with s_is_last marking the item that ends the token. s_no_char lets
// an item carry no character (an empty token ends this way), and
// s_within_quotes is sampled on the last item only. Each last item yields
// one item on the m_ channel: m_token_type (blank, string, integer, real,
// open bracket, close bracket, word); other items yield nothing.
// Timing: an accepted item is held in the input register, where the token
// flags are updated and the type is worked out; when a last item leaves the
// input register, the result register takes its type and m_valid rises.
// One item is taken every cycle while the result side keeps up.
// Stall: while a result waits in the output register, items that are not
// last keep flowing; a last item waits in the input register until the
// result register is free.
// Reset: aresetn (synchronous, active low) empties both registers and
// returns the token flags to the start of a new token.
module numeric_token_classifier_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_no_char,
    input  logic       s_is_last,
    input  logic       s_within_quotes,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_token_type
);

    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_no_char_reg;
    logic       in_last_reg;
    logic       in_quoted_reg;

    ntc_pkg::tok_state_t  tok_state_reg;
    ntc_pkg::tok_state_t  tok_state_upd;
    ntc_pkg::token_type_t type_calc;

    logic                 m_valid_reg;
    ntc_pkg::token_type_t m_type_reg;

    logic out_free;
    logic consume;

    assign out_free = !m_valid_reg || m_ready;
    // only a last item needs room in the result register
    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ch_reg      <= s_ch;
            in_no_char_reg <= s_no_char;
            in_last_reg    <= s_is_last;
            in_quoted_reg  <= s_within_quotes;
        end
    end

    ntc_char_update u_update (
        .cur     (tok_state_reg),
        .ch      (in_ch_reg),
        .no_char (in_no_char_reg),
        .nxt     (tok_state_upd)
    );

    ntc_classify u_classify (
        .st         (tok_state_upd),
        .quoted     (in_quoted_reg),
        .token_type (type_calc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_state_reg <= ntc_pkg::TOK_RESET;
        end else if (consume) begin
            tok_state_reg <= in_last_reg ? ntc_pkg::TOK_RESET : tok_state_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (consume && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && in_last_reg) begin
            m_type_reg <= type_calc;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_token_type = m_type_reg;

    // the saturating character count never reaches three
    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_state_reg.char_count != 2'd3)
        else $error("character count past saturation");

    // an item that does not end a token is never held back
    a_mid_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_last_reg) |-> consume)
        else $error("mid-token item stalled");

    // a consumed last item shows up as a result in the next cycle
    a_last_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_last_reg) |=> (m_valid_reg && m_type_reg == $past(type_calc)))
        else $error("last item lost its result");

    // flags are back at the start of a token after a result is produced
    a_flags_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_last_reg) |=> (tok_state_reg == ntc_pkg::TOK_RESET))
        else $error("token flags not cleared");

endmodule

/* tb/numeric_token_classifier_unit_tb.sv */
// self-checking testbench of the numeric token classifier unit
`timescale 1ns / 100ps

module numeric_token_classifier_unit_tb;

    typedef struct {
        logic [7:0] ch;
        logic       no_char;
        logic       is_last;
        logic       quoted;
    } tok_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_ch = 8'h00;
    logic       s_no_char = 1'b0;
    logic       s_is_last = 1'b0;
    logic       s_within_quotes = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_token_type;

    tok_item_t            pending_items[$];
    ntc_pkg::token_type_t expected_types[$];
    logic [7:0]           tok_chars[$];
    tok_item_t            next_item;
    ntc_pkg::token_type_t want_type;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   fail_count = 0;
    int                   queued_count = 0;

    // classifier state kept by the testbench
    logic [1:0]      tk_count;
    logic            tk_lead_zero;
    logic            tk_hex_lead;
    logic            tk_hex_tail_ok;
    logic            tk_sign;
    logic            tk_point;
    logic            tk_exp;
    logic            tk_may_int;
    logic            tk_may_float;
    logic            tk_digits;
    ntc_pkg::brace_t tk_brace;

    numeric_token_classifier_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .s_no_char      (s_no_char),
        .s_is_last      (s_is_last),
        .s_within_quotes(s_within_quotes),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_type   (m_token_type)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic bit is_dec(logic [7:0] c);
        return c >= ntc_pkg::CH_ZERO && c <= ntc_pkg::CH_NINE;
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return is_dec(c)
            || (c >= ntc_pkg::CH_LC_A && c <= ntc_pkg::CH_LC_F)
            || (c >= ntc_pkg::CH_UC_A && c <= ntc_pkg::CH_UC_F);
    endfunction

    task automatic clear_token();
        tk_count       = 2'd0;
        tk_lead_zero   = 1'b0;
        tk_hex_lead    = 1'b0;
        tk_hex_tail_ok = 1'b1;
        tk_sign        = 1'b0;
        tk_point       = 1'b0;
        tk_exp         = 1'b0;
        tk_may_int     = 1'b1;
        tk_may_float   = 1'b1;
        tk_digits      = 1'b0;
        tk_brace       = ntc_pkg::BRACE_NONE;
    endtask

    task automatic take_char(logic [7:0] c);
        if (tk_count == 2'd0) begin
            tk_lead_zero = (c == ntc_pkg::CH_ZERO);
            tk_brace = (c == ntc_pkg::CH_LBRACE) ? ntc_pkg::BRACE_OPEN :
                       (c == ntc_pkg::CH_RBRACE) ? ntc_pkg::BRACE_CLOSE :
                       ntc_pkg::BRACE_NONE;
        end else if (tk_count == 2'd1) begin
            tk_hex_lead = tk_lead_zero && (c == ntc_pkg::CH_X);
        end else if (!is_hex(c)) begin
            tk_hex_tail_ok = 1'b0;
        end
        if (tk_count < ntc_pkg::CNT_SAT)
            tk_count = tk_count + 2'd1;

        // grammar flags freeze after the first failure
        if (tk_may_float) begin
            if (c == ntc_pkg::CH_PLUS || c == ntc_pkg::CH_MINUS) begin
                if (tk_sign) begin
                    tk_may_int = 1'b0;
                    tk_may_float = 1'b0;
                end else begin
                    tk_sign = 1'b1;
                end
            end else if (is_dec(c)) begin
                tk_digits = 1'b1;
            end else if (c == ntc_pkg::CH_POINT) begin
                if (tk_point) begin
                    tk_may_int = 1'b0;
                    tk_may_float = 1'b0;
                end else begin
                    tk_point = 1'b1;
                    tk_may_int = 1'b0;
                end
            end else if (c == ntc_pkg::CH_LC_E || c == ntc_pkg::CH_UC_E) begin
                if (tk_exp || !tk_digits) begin
                    tk_may_int = 1'b0;
                    tk_may_float = 1'b0;
                end else begin
                    // exponent starts a new part
                    tk_exp = 1'b1;
                    tk_may_int = 1'b0;
                    tk_point = 1'b0;
                    tk_sign = 1'b0;
                    tk_digits = 1'b0;
                end
            end else begin
                tk_may_int = 1'b0;
                tk_may_float = 1'b0;
            end
        end
    endtask

    function automatic ntc_pkg::token_type_t classify_token(logic quoted);
        if (tk_count == 2'd0) return ntc_pkg::TT_BLANK;
        if (quoted) return ntc_pkg::TT_STRING;
        if (tk_count >= ntc_pkg::CNT_SAT && tk_hex_lead && tk_hex_tail_ok)
            return ntc_pkg::TT_INTEGER;
        if (tk_may_int && tk_digits) return ntc_pkg::TT_INTEGER;
        if (tk_may_float && tk_digits) return ntc_pkg::TT_REAL;
        if (tk_brace == ntc_pkg::BRACE_OPEN) return ntc_pkg::TT_OPEN;
        if (tk_brace == ntc_pkg::BRACE_CLOSE) return ntc_pkg::TT_CLOSE;
        return ntc_pkg::TT_WORD;
    endfunction

    task automatic push_item(logic [7:0] ch, logic no_char, logic is_last, logic quoted);
        tok_item_t it;
        it.ch = ch;
        it.no_char = no_char;
        it.is_last = is_last;
        it.quoted = quoted;
        pending_items.push_back(it);
        queued_count++;
    endtask

    // sends tok_chars as one token, optionally with empty items in between or an empty item at its end
    task automatic push_token(bit quoted, bit blank_end, bit gaps);
        int n;
        n = tok_chars.size();
        for (int i = 0; i < n; i++) begin
            if (gaps && $urandom_range(15) == 0)
                push_item(8'($urandom_range(255)), 1'b1, 1'b0, 1'($urandom_range(1)));
            if (i == n - 1 && !blank_end)
                push_item(tok_chars[i], 1'b0, 1'b1, quoted);
            else
                push_item(tok_chars[i], 1'b0, 1'b0, 1'($urandom_range(1)));
        end
        if (n == 0 || blank_end)
            push_item(8'($urandom_range(255)), 1'b1, 1'b1, quoted);
    endtask

    task automatic push_text(string s, bit quoted);
        tok_chars.delete();
        for (int i = 0; i < s.len(); i++)
            tok_chars.push_back(s[i]);
        push_token(quoted, 1'b0, 1'b0);
    endtask

    task automatic add_digits(int lo, int hi);
        int n;
        n = $urandom_range(hi, lo);
        for (int i = 0; i < n; i++)
            tok_chars.push_back(8'(ntc_pkg::CH_ZERO + $urandom_range(9)));
    endtask

    task automatic random_token();
        string noise_set;
        string hex_set;
        int    kind;
        int    n;
        noise_set = "+-.eEx0159aAfFgG{} \"";
        hex_set = "0123456789abcdefABCDEF";
        tok_chars.delete();
        kind = $urandom_range(99);
        if (kind < 45) begin
            if ($urandom_range(2) == 0)
                tok_chars.push_back($urandom_range(1) ? ntc_pkg::CH_PLUS : ntc_pkg::CH_MINUS);
            add_digits(0, 4);
            if ($urandom_range(1)) begin
                tok_chars.push_back(ntc_pkg::CH_POINT);
                add_digits(0, 3);
            end
            if ($urandom_range(2) == 0) begin
                tok_chars.push_back($urandom_range(1) ? ntc_pkg::CH_LC_E : ntc_pkg::CH_UC_E);
                if ($urandom_range(1))
                    tok_chars.push_back($urandom_range(1) ? ntc_pkg::CH_PLUS
                                                          : ntc_pkg::CH_MINUS);
                add_digits(0, 3);
            end
        end else if (kind < 60) begin
            tok_chars.push_back(ntc_pkg::CH_ZERO);
            tok_chars.push_back($urandom_range(7) == 0 ? 8'(ntc_pkg::CH_UC_A + 23)
                                                       : ntc_pkg::CH_X);
            n = $urandom_range(4);
            for (int i = 0; i < n; i++)
                tok_chars.push_back(hex_set[$urandom_range(hex_set.len() - 1)]);
        end else if (kind < 70) begin
            tok_chars.push_back($urandom_range(1) ? ntc_pkg::CH_LBRACE : ntc_pkg::CH_RBRACE);
            n = $urandom_range(3);
            for (int i = 0; i < n; i++)
                tok_chars.push_back(noise_set[$urandom_range(noise_set.len() - 1)]);
        end else if (kind < 85) begin
            n = $urandom_range(5, 1);
            for (int i = 0; i < n; i++)
                tok_chars.push_back(noise_set[$urandom_range(noise_set.len() - 1)]);
        end else if (kind < 93) begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++)
                tok_chars.push_back(8'($urandom_range(255)));
        end
        // occasionally break a well-formed token
        if (kind < 60 && tok_chars.size() > 0 && $urandom_range(6) == 0)
            tok_chars.insert($urandom_range(tok_chars.size()),
                             noise_set[$urandom_range(noise_set.len() - 1)]);
        push_token($urandom_range(9) == 0, $urandom_range(7) == 0, 1'b1);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_types.size() != 0)
            @(negedge aclk);
    endtask

    // driver: predicts on every accepted item, then offers the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (!s_no_char)
                    take_char(s_ch);
                if (s_is_last) begin
                    expected_types.push_back(classify_token(s_within_quotes));
                    clear_token();
                end
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_ch <= next_item.ch;
                    s_no_char <= next_item.no_char;
                    s_is_last <= next_item.is_last;
                    s_within_quotes <= next_item.quoted;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted result against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_types.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0d",
                         $time, m_token_type);
                fail_count++;
            end else begin
                want_type = expected_types.pop_front();
                if (m_token_type !== want_type) begin
                    $display("%0t: token_type mismatch, expected %0d actual %0d",
                             $time, want_type, m_token_type);
                    fail_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        clear_token();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed tokens
        push_item(8'h41, 1'b1, 1'b1, 1'b0);
        push_item(8'h22, 1'b1, 1'b1, 1'b1);
        push_item(8'h20, 1'b1, 1'b0, 1'b0);
        push_item(8'(ntc_pkg::CH_ZERO + 5), 1'b0, 1'b1, 1'b0);
        push_text("0x", 1'b0);
        push_text("0xF", 1'b0);
        push_text("1e", 1'b0);
        push_text("+.5", 1'b0);
        push_text("e1", 1'b0);
        push_text("{", 1'b0);
        push_text("}", 1'b0);
        push_item(8'h00, 1'b0, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b1, 1'b0);
        push_text("9", 1'b1);
        push_text("1..", 1'b0);
        push_text("--", 1'b0);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                3: begin send_idle_pct = 18; recv_stall_pct = 18; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            queued_count = 0;
            while (queued_count < 320)
                random_token();
            // sender holds off until every result of the phase is back
            wait_drained();
        end

        repeat (20) @(negedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ntc_pkg.sv
hw/rtl/ntc_char_update.sv
hw/rtl/ntc_classify.sv
hw/rtl/numeric_token_classifier_unit.sv
tb/numeric_token_classifier_unit_tb.sv
